// ===== rtl/gaussian_blur_3x3_replicate_defines.svh =====
// ----------------------------------------------------------------------------
// gaussian blur assertion macros
// shared property shorthands for the checker of the blur block
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_REPLICATE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_REPLICATE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define GB3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define GB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gb3_pkg.sv =====
// ----------------------------------------------------------------------------
// gb3_pkg
// shared types and constants of the 3x3 binomial blur
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CH     = 4;
    localparam int SUM_W      = 12;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int NCH_W      = 3;
    localparam int ROW_W      = 17;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 12'd2048;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 16'd1;
    localparam logic [NCH_W-1:0]    RST_CHANNEL_COUNT = 3'd3;

    // one neighbourhood column of a channel, index 0 is the top row
    typedef logic [2:0][CHAN_W-1:0] col_t;

    // one result item
    typedef struct packed {
        logic [NUM_CH-1:0][CHAN_W-1:0] chan;
        logic                          eos;
        logic                          eof;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_3x3_replicate.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_replicate
// 3x3 binomial blur over a raster pixel stream with replicated borders
// ----------------------------------------------------------------------------
// result path: the input item that causes the result is accepted into the read
//   stage registers (line memory read), then its lane sums go into the queue
//   once it has room for a pair and out_valid rises; the second of a pair follows
// throughput: one input item per cycle while the output queue has room for a pair;
//   the last column gives two results (one at width 1), the four-entry output queue absorbs the extra one
// reset: counters, window and queue clear at once; the line memory is not
//   cleared and needs no clearing pass, items are taken straight after reset
`default_nettype none

module gaussian_blur_3x3_replicate
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // input items
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [gb3_pkg::CHAN_W-1:0]        in_chan0,
    input  wire logic [gb3_pkg::CHAN_W-1:0]        in_chan1,
    input  wire logic [gb3_pkg::CHAN_W-1:0]        in_chan2,
    input  wire logic [gb3_pkg::CHAN_W-1:0]        in_chan3,

    // result items
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [gb3_pkg::CHAN_W-1:0]             out_chan0,
    output logic [gb3_pkg::CHAN_W-1:0]             out_chan1,
    output logic [gb3_pkg::CHAN_W-1:0]             out_chan2,
    output logic [gb3_pkg::CHAN_W-1:0]             out_chan3,
    output logic                                   end_of_step,
    output logic                                   end_of_frame
);

    // widths that follow from the parameters
    localparam int WORD_W = gb3_pkg::CHAN_W * MAX_CHANNELS;
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > gb3_pkg::WIDTH_W + 1) ? ADDR_W + 1
                                                               : gb3_pkg::WIDTH_W + 1;

    // per-item flags carried from the read stage to the window stage
    typedef struct packed {
        logic last_col;
        logic drain;
        logic row_ge1;
        logic row_ge2;
        logic col_zero;
    } s1_ctl_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [gb3_pkg::WIDTH_W-1:0]  width_cfg_reg;
    logic [gb3_pkg::HEIGHT_W-1:0] height_cfg_reg;
    logic [gb3_pkg::NCH_W-1:0]    nch_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= gb3_pkg::RST_IMAGE_WIDTH;
            height_cfg_reg <= gb3_pkg::RST_IMAGE_HEIGHT;
            nch_cfg_reg    <= gb3_pkg::RST_CHANNEL_COUNT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH:
                    width_cfg_reg  <= cfg_wdata[gb3_pkg::WIDTH_W-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT:
                    height_cfg_reg <= cfg_wdata[gb3_pkg::HEIGHT_W-1:0];
                gb3_pkg::REG_CHANNEL_COUNT:
                    nch_cfg_reg    <= cfg_wdata[gb3_pkg::NCH_W-1:0];
                default:
                    ;  // writes past the register list are dropped
            endcase
        end
    end

    // effective values: width into [1, MAX_WIDTH], height at least 1,
    // channel count into [1, MAX_CHANNELS]
    logic [CMP_W-1:0]              eff_width;
    logic [gb3_pkg::ROW_W-1:0]     eff_height;
    logic [gb3_pkg::NCH_W-1:0]     eff_nch;

    always_comb
    begin
        eff_width = CMP_W'(width_cfg_reg);
        if (eff_width == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (eff_width > CMP_W'(MAX_WIDTH))
        begin
            eff_width = CMP_W'(MAX_WIDTH);
        end

        eff_height = (height_cfg_reg == '0) ? gb3_pkg::ROW_W'(1)
                                            : gb3_pkg::ROW_W'(height_cfg_reg);

        eff_nch = nch_cfg_reg;
        if (eff_nch == '0)
        begin
            eff_nch = gb3_pkg::NCH_W'(1);
        end
        else if (eff_nch > gb3_pkg::NCH_W'(MAX_CHANNELS))
        begin
            eff_nch = gb3_pkg::NCH_W'(MAX_CHANNELS);
        end
    end

    // ------------------------------------------------------------------
    // read stage: position counters and line memory read
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]          col_cnt_reg;
    logic [ADDR_W-1:0]          col_cnt_next;
    logic [gb3_pkg::ROW_W-1:0]  row_cnt_reg;
    logic [gb3_pkg::ROW_W-1:0]  row_cnt_next;
    logic                       accept;
    s1_ctl_t                    s0_ctl;
    logic [WORD_W-1:0]          s0_pix;
    logic [gb3_pkg::NUM_CH*gb3_pkg::CHAN_W-1:0] in_all;

    // window stage registers
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    s1_ctl_t                    s1_ctl_reg;
    logic [WORD_W-1:0]          s1_pix_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_advance;
    logic                       fifo_room;

    assign in_all = {in_chan3, in_chan2, in_chan1, in_chan0};
    assign s0_pix = in_all[WORD_W-1:0];

    // a column at or past the last is handled as the last one; a row at or
    // past the height is the drain row
    always_comb
    begin
        s0_ctl.last_col = ((CMP_W'(col_cnt_reg) + CMP_W'(1)) >= eff_width);
        s0_ctl.drain    = (row_cnt_reg >= eff_height);
        s0_ctl.row_ge1  = (row_cnt_reg >= gb3_pkg::ROW_W'(1));
        s0_ctl.row_ge2  = (row_cnt_reg >= gb3_pkg::ROW_W'(2));
        s0_ctl.col_zero = (col_cnt_reg == '0);
    end

    // the window stage moves on only while the queue has space for a pair
    assign s1_advance = s1_valid_reg && fifo_room;
    assign in_ready   = !s1_valid_reg || fifo_room;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            if (s0_ctl.last_col)
            begin
                col_cnt_next = '0;
                // the drain row ends the frame
                row_cnt_next = s0_ctl.drain ? '0 : row_cnt_reg + gb3_pkg::ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + ADDR_W'(1);
            end
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // item payload moves with its read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg  <= s0_ctl;
            s1_pix_reg  <= s0_pix;
            s1_addr_reg <= col_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // line memory: row 1 is the row above the input, row 2 the one above it
    // ------------------------------------------------------------------
    logic              lb_wr_en;
    logic [WORD_W-1:0] rd_row1;
    logic [WORD_W-1:0] rd_row2;

    // the drain row leaves the stored rows alone
    assign lb_wr_en = s1_advance && !s1_ctl_reg.drain;

    gb3_line_buf
    #(
        .DEPTH  (MAX_WIDTH),
        .WORD_W (WORD_W),
        .ADDR_W (ADDR_W)
    )
    u_line_buf
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .wr_en   (lb_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_row1 (s1_pix_reg),
        .wr_row2 (rd_row1),
        .rd_row1 (rd_row1),
        .rd_row2 (rd_row2)
    );

    // ------------------------------------------------------------------
    // window stage: new column with edge replication, two sliding columns
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] new_col [3];
    logic [WORD_W-1:0] win_left_reg [3];
    logic [WORD_W-1:0] win_mid_reg [3];
    logic [WORD_W-1:0] b_left [3];
    logic              has_a;
    logic              has_b;

    // top row repeats the middle near the top edge, bottom row repeats
    // it in the drain row
    always_comb
    begin
        new_col[1] = rd_row1;
        new_col[0] = s1_ctl_reg.row_ge2 ? rd_row2 : rd_row1;
        new_col[2] = s1_ctl_reg.drain ? rd_row1 : s1_pix_reg;
    end

    // result a: centre on the previous column; result b: right edge,
    // which on the first column also replicates to the left
    always_comb
    begin
        has_a = !s1_ctl_reg.col_zero && s1_ctl_reg.row_ge1;
        has_b = s1_ctl_reg.last_col && s1_ctl_reg.row_ge1;
        for (int k = 0; k < 3; k++)
        begin
            b_left[k] = s1_ctl_reg.col_zero ? new_col[k] : win_mid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_left_reg[k] <= '0;
                win_mid_reg[k]  <= '0;
            end
        end
        else if (s1_advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_left_reg[k] <= s1_ctl_reg.col_zero ? new_col[k] : win_mid_reg[k];
                win_mid_reg[k]  <= new_col[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // lanes: one kernel pair per channel
    // ------------------------------------------------------------------
    logic [gb3_pkg::NUM_CH-1:0][gb3_pkg::CHAN_W-1:0] res_a;
    logic [gb3_pkg::NUM_CH-1:0][gb3_pkg::CHAN_W-1:0] res_b;

    for (genvar ch = 0; ch < gb3_pkg::NUM_CH; ch++)
    begin : g_lane
        if (ch < MAX_CHANNELS)
        begin : g_used
            gb3_pkg::col_t a_left;
            gb3_pkg::col_t a_mid;
            gb3_pkg::col_t a_right;
            gb3_pkg::col_t b_lft;
            gb3_pkg::col_t b_mid;
            logic          lane_en;

            for (genvar k = 0; k < 3; k++)
            begin : g_row
                assign a_left[k]  = win_left_reg[k][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
                assign a_mid[k]   = win_mid_reg[k][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
                assign a_right[k] = new_col[k][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
                assign b_lft[k]   = b_left[k][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
                assign b_mid[k]   = new_col[k][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
            end

            // channels past the configured count give zero
            assign lane_en = (gb3_pkg::NCH_W'(ch) < eff_nch);

            gb3_lane u_lane_a
            (
                .left_col  (a_left),
                .mid_col   (a_mid),
                .right_col (a_right),
                .enable    (lane_en),
                .result    (res_a[ch])
            );

            gb3_lane u_lane_b
            (
                .left_col  (b_lft),
                .mid_col   (b_mid),
                .right_col (b_mid),
                .enable    (lane_en),
                .result    (res_b[ch])
            );
        end
        else
        begin : g_unused
            assign res_a[ch] = '0;
            assign res_b[ch] = '0;
        end
    end

    // ------------------------------------------------------------------
    // merge: lane results become result items in the output queue
    // ------------------------------------------------------------------
    gb3_pkg::out_item_t item_a;
    gb3_pkg::out_item_t item_b;
    gb3_pkg::out_item_t head_item;

    always_comb
    begin
        item_a.chan = res_a;
        item_a.eos  = !has_b;
        item_a.eof  = 1'b0;
        item_b.chan = res_b;
        item_b.eos  = 1'b1;
        item_b.eof  = s1_ctl_reg.drain;
    end

    gb3_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (s1_advance && has_a),
        .item_a    (item_a),
        .push_b    (s1_advance && has_b),
        .item_b    (item_b),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (head_item)
    );

    assign out_chan0    = head_item.chan[0];
    assign out_chan1    = head_item.chan[1];
    assign out_chan2    = head_item.chan[2];
    assign out_chan3    = head_item.chan[3];
    assign end_of_step  = head_item.eos;
    assign end_of_frame = head_item.eof;

endmodule

`default_nettype wire

// ===== rtl/gb3_lane.sv =====
// ----------------------------------------------------------------------------
// gb3_lane
// one channel of the 1 2 1 binomial kernel, sum shifted right by four
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_lane
(
    input  wire gb3_pkg::col_t               left_col,
    input  wire gb3_pkg::col_t               mid_col,
    input  wire gb3_pkg::col_t               right_col,
    input  wire logic                        enable,
    output logic [gb3_pkg::CHAN_W-1:0]       result
);

    logic [gb3_pkg::SUM_W-1:0] top_sum;
    logic [gb3_pkg::SUM_W-1:0] mid_sum;
    logic [gb3_pkg::SUM_W-1:0] bot_sum;
    logic [gb3_pkg::SUM_W-1:0] total;

    // each row is 1 2 1, the middle row counts twice
    always_comb
    begin
        top_sum = gb3_pkg::SUM_W'(left_col[0]) + (gb3_pkg::SUM_W'(mid_col[0]) << 1)
                + gb3_pkg::SUM_W'(right_col[0]);
        mid_sum = gb3_pkg::SUM_W'(left_col[1]) + (gb3_pkg::SUM_W'(mid_col[1]) << 1)
                + gb3_pkg::SUM_W'(right_col[1]);
        bot_sum = gb3_pkg::SUM_W'(left_col[2]) + (gb3_pkg::SUM_W'(mid_col[2]) << 1)
                + gb3_pkg::SUM_W'(right_col[2]);
        total   = top_sum + (mid_sum << 1) + bot_sum;
        result  = enable ? total[gb3_pkg::SUM_W-1:4] : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/gb3_line_buf.sv =====
// ----------------------------------------------------------------------------
// gb3_line_buf
// two row memories with registered read and write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_buf
#(
    parameter int DEPTH  = 2048,
    parameter int WORD_W = 32,
    parameter int ADDR_W = 11
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_row1,
    input  wire logic [WORD_W-1:0] wr_row2,
    output logic      [WORD_W-1:0] rd_row1,
    output logic      [WORD_W-1:0] rd_row2
);

    logic [WORD_W-1:0] row1_mem_reg [DEPTH];
    logic [WORD_W-1:0] row2_mem_reg [DEPTH];
    logic [WORD_W-1:0] rd_row1_reg;
    logic [WORD_W-1:0] rd_row2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row1_mem_reg[wr_addr] <= wr_row1;
            row2_mem_reg[wr_addr] <= wr_row2;
        end
    end

    // same address written this cycle: take the new words
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_row1_reg <= wr_row1;
                rd_row2_reg <= wr_row2;
            end
            else
            begin
                rd_row1_reg <= row1_mem_reg[rd_addr];
                rd_row2_reg <= row2_mem_reg[rd_addr];
            end
        end
    end

    assign rd_row1 = rd_row1_reg;
    assign rd_row2 = rd_row2_reg;

endmodule

`default_nettype wire

// ===== rtl/gb3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gb3_out_fifo
// queues result items, takes up to two a cycle, gives one while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_out_fifo
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_a,
    input  wire gb3_pkg::out_item_t    item_a,
    input  wire logic                  push_b,
    input  wire gb3_pkg::out_item_t    item_b,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gb3_pkg::out_item_t         out_item
);

    gb3_pkg::out_item_t                  entry_reg [gb3_pkg::OUT_DEPTH];
    logic [gb3_pkg::OUT_PTR_W-1:0]       wr_ptr_reg;
    logic [gb3_pkg::OUT_PTR_W-1:0]       wr_ptr_next;
    logic [gb3_pkg::OUT_PTR_W-1:0]       rd_ptr_reg;
    logic [gb3_pkg::OUT_PTR_W-1:0]       rd_ptr_next;
    logic [gb3_pkg::OUT_CNT_W-1:0]       count_reg;
    logic [gb3_pkg::OUT_CNT_W-1:0]       count_next;
    logic [gb3_pkg::OUT_CNT_W-1:0]       push_n;
    logic                                pop;
    gb3_pkg::out_item_t                  first_item;

    assign out_valid  = (count_reg != '0);
    assign out_item   = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= gb3_pkg::OUT_CNT_W'(gb3_pkg::OUT_DEPTH - 2));
    assign first_item = push_a ? item_a : item_b;

    always_comb
    begin
        push_n      = gb3_pkg::OUT_CNT_W'(push_a) + gb3_pkg::OUT_CNT_W'(push_b);
        wr_ptr_next = wr_ptr_reg + gb3_pkg::OUT_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + gb3_pkg::OUT_PTR_W'(pop);
        count_next  = count_reg + push_n - gb3_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a || push_b)
        begin
            entry_reg[wr_ptr_reg] <= first_item;
        end
        if (push_a && push_b)
        begin
            entry_reg[wr_ptr_reg + gb3_pkg::OUT_PTR_W'(1)] <= item_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gb3_checker.sv =====
// ----------------------------------------------------------------------------
// gb3_checker
// port-level checks on the blur block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_blur_3x3_replicate_defines.svh"

module gb3_checker
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [gb3_pkg::CHAN_W-1:0] out_chan0,
    input wire logic [gb3_pkg::CHAN_W-1:0] out_chan1,
    input wire logic [gb3_pkg::CHAN_W-1:0] out_chan2,
    input wire logic [gb3_pkg::CHAN_W-1:0] out_chan3,
    input wire logic                       end_of_step,
    input wire logic                       end_of_frame
);

    logic in_taken;

    assign in_taken = in_valid && in_ready;

    // a stalled result item holds
    `GB3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_chan0) && $stable(out_chan1) && $stable(out_chan2)
        && $stable(out_chan3) && $stable(end_of_step) && $stable(end_of_frame),
        "result item changed while stalled")

    // the frame's last pixel closes its input item
    `GB3_ASSERT_NOW(a_eof_is_eos, out_valid && end_of_frame, end_of_step,
        "end_of_frame without end_of_step")

    // the second result of a pair is queued with the first
    `GB3_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !end_of_step, out_valid,
        "second result of an item missing")

    // an item taken must leave out_valid free of x
    `GB3_ASSERT_NOW(a_ready_known, in_taken, !$isunknown(out_valid),
        "output valid unknown while taking items")

endmodule

bind gaussian_blur_3x3_replicate gb3_checker u_gb3_checker (.*);

`default_nettype wire

// ===== sim/tb_gaussian_blur_3x3_replicate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_replicate
// self-checking bench for the 3x3 binomial blur: a queue-fed pixel driver and
// a result monitor run against an in-bench model of the window and line store,
// over hand-picked frames, mid-frame register changes and random frames
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_replicate;

    localparam int MAX_W         = 2048;
    localparam int MAX_CH        = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 300;
    // settle time after the last result is back, before touching registers
    localparam int SETTLE_CYCLES = 8;

    // index past the last register, writes to it must change nothing
    localparam logic [gb3_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [gb3_pkg::NUM_CH-1:0][gb3_pkg::CHAN_W-1:0] pixel_t;
    // one neighbourhood column of packed pixels: top, middle, bottom
    typedef logic [2:0][31:0] tap_col_t;

    typedef enum int
    {
        PX_NOISE,
        PX_EXTREME,
        PX_SMOOTH
    } px_style_e;

    // ------------------------------------------------------------------
    // clock, reset and block ports, all known from time zero
    // ------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [gb3_pkg::CHAN_W-1:0]     in_chan0  = '0;
    logic [gb3_pkg::CHAN_W-1:0]     in_chan1  = '0;
    logic [gb3_pkg::CHAN_W-1:0]     in_chan2  = '0;
    logic [gb3_pkg::CHAN_W-1:0]     in_chan3  = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [gb3_pkg::CHAN_W-1:0]     out_chan0;
    logic [gb3_pkg::CHAN_W-1:0]     out_chan1;
    logic [gb3_pkg::CHAN_W-1:0]     out_chan2;
    logic [gb3_pkg::CHAN_W-1:0]     out_chan3;
    logic                           end_of_step;
    logic                           end_of_frame;

    always #4 clk = ~clk;

    gaussian_blur_3x3_replicate
    #(
        .MAX_WIDTH    (MAX_W),
        .MAX_CHANNELS (MAX_CH)
    )
    DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_chan0     (in_chan0),
        .in_chan1     (in_chan1),
        .in_chan2     (in_chan2),
        .in_chan3     (in_chan3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_chan0    (out_chan0),
        .out_chan1    (out_chan1),
        .out_chan2    (out_chan2),
        .out_chan3    (out_chan3),
        .end_of_step  (end_of_step),
        .end_of_frame (end_of_frame)
    );

    // ------------------------------------------------------------------
    // bench bookkeeping
    // ------------------------------------------------------------------
    pixel_t             pixel_q [$];     // items waiting to be offered
    gb3_pkg::out_item_t blurred_q [$];   // blurred pixels still owed by the block
    pixel_t             on_bus;          // item currently held on the input port
    int                 items_queued   = 0;
    int                 items_accepted = 0;
    int                 results_seen   = 0;
    int                 frames_run     = 0;
    int                 errors         = 0;
    int                 cycles         = 0;
    logic               no_gaps        = 1'b0;   // both sides run flat out while set

    // ------------------------------------------------------------------
    // own copy of the block's state and registers
    // ------------------------------------------------------------------
    logic [31:0]                  line_mem [0:2*MAX_W-1];   // row above, then the one above
    tap_col_t                     win_left   = '0;
    tap_col_t                     win_mid    = '0;
    logic [10:0]                  px_col     = '0;
    logic [16:0]                  px_row     = '0;
    logic [gb3_pkg::WIDTH_W-1:0]  reg_width  = gb3_pkg::RST_IMAGE_WIDTH;
    logic [gb3_pkg::HEIGHT_W-1:0] reg_height = gb3_pkg::RST_IMAGE_HEIGHT;
    logic [gb3_pkg::NCH_W-1:0]    reg_chans  = gb3_pkg::RST_CHANNEL_COUNT;

    // register values as the block uses them, out-of-range ones saturated
    function automatic logic [gb3_pkg::WIDTH_W-1:0] active_width();
        if (reg_width == '0)
            return 12'd1;
        if (reg_width > 12'(MAX_W))
            return 12'(MAX_W);
        return reg_width;
    endfunction

    function automatic logic [gb3_pkg::HEIGHT_W-1:0] active_height();
        return (reg_height == '0) ? 16'd1 : reg_height;
    endfunction

    function automatic logic [gb3_pkg::NCH_W-1:0] active_chans();
        if (reg_chans == '0)
            return 3'd1;
        if (reg_chans > 3'(MAX_CH))
            return 3'(MAX_CH);
        return reg_chans;
    endfunction

    // weighted 1 2 1 / 2 4 2 / 1 2 1 sum over three columns, truncated by 16
    function automatic gb3_pkg::out_item_t blur_tap(tap_col_t l, tap_col_t m, tap_col_t r,
                                                    logic [gb3_pkg::NCH_W-1:0] nch);
        gb3_pkg::out_item_t        res;
        logic [gb3_pkg::SUM_W-1:0] acc;
        res = '0;
        for (int ch = 0; ch < gb3_pkg::NUM_CH; ch++)
        begin
            if (ch < nch)
            begin
                acc = gb3_pkg::SUM_W'(l[0][8*ch +: 8] + 2 * m[0][8*ch +: 8]
                                      + r[0][8*ch +: 8]
                                      + 2 * l[1][8*ch +: 8] + 4 * m[1][8*ch +: 8]
                                      + 2 * r[1][8*ch +: 8]
                                      + l[2][8*ch +: 8] + 2 * m[2][8*ch +: 8]
                                      + r[2][8*ch +: 8]);
                res.chan[ch] = acc[gb3_pkg::SUM_W-1:4];
            end
        end
        return res;
    endfunction

    // one accepted pixel: update window, line store and counters, queue what it yields
    function automatic void blur_predict(pixel_t px);
        logic [gb3_pkg::WIDTH_W-1:0]  w;
        logic [gb3_pkg::HEIGHT_W-1:0] h;
        logic [gb3_pkg::NCH_W-1:0]    nch;
        logic                         last_col;
        logic                         drain;
        logic [31:0]                  word;
        tap_col_t                     fresh;
        gb3_pkg::out_item_t           res [2];
        int                           n;
        int                           ci;
        w        = active_width();
        h        = active_height();
        nch      = active_chans();
        last_col = ({1'b0, px_col} + 12'd1) >= w;
        drain    = px_row >= {1'b0, h};
        ci       = int'(px_col);
        word     = px;

        // new column, rows clamped at the top edge and at the drain row
        fresh[1] = line_mem[ci];
        fresh[0] = (px_row >= 17'd2) ? line_mem[MAX_W + ci] : fresh[1];
        fresh[2] = drain ? fresh[1] : word;
        if (!drain)
        begin
            line_mem[MAX_W + ci] = line_mem[ci];
            line_mem[ci]         = word;
        end

        n = 0;
        if (px_col == '0)
        begin
            // left edge replicates the first column
            win_left = fresh;
            win_mid  = fresh;
        end
        else
        begin
            if (px_row != '0)
            begin
                res[n] = blur_tap(win_left, win_mid, fresh, nch);
                n++;
            end
            win_left = win_mid;
            win_mid  = fresh;
        end
        // right edge replicates the last column
        if (last_col && px_row != '0)
        begin
            res[n]     = blur_tap(win_left, win_mid, win_mid, nch);
            res[n].eof = drain;
            n++;
        end
        if (n > 0)
            res[n-1].eos = 1'b1;
        for (int i = 0; i < n; i++)
            blurred_q.push_back(res[i]);

        if (last_col)
        begin
            px_col = '0;
            px_row = drain ? '0 : px_row + 17'd1;
        end
        else
        begin
            px_col = px_col + 11'd1;
        end
    endfunction

    // items still needed to close the current frame, drain row included
    function automatic int items_to_frame_end();
        int c;
        int r;
        int cnt;
        bit done;
        c    = int'(px_col);
        r    = int'(px_row);
        cnt  = 0;
        done = 1'b0;
        while (!done)
        begin
            cnt++;
            if (c + 1 >= int'(active_width()))
            begin
                if (r >= int'(active_height()))
                    done = 1'b1;
                else
                begin
                    c = 0;
                    r++;
                end
            end
            else
            begin
                c++;
            end
        end
        return cnt;
    endfunction

    function automatic pixel_t make_pixel(px_style_e style);
        pixel_t px;
        for (int ch = 0; ch < gb3_pkg::NUM_CH; ch++)
        begin
            case (style)
                PX_NOISE:   px[ch] = 8'($urandom);
                PX_EXTREME: px[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:    px[ch] = 8'($urandom_range(96, 160));
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(pixel_t px);
        pixel_q.push_back(px);
        items_queued++;
    endtask

    task automatic queue_pixels(int count, px_style_e style);
        for (int i = 0; i < count; i++)
            push_pixel(make_pixel(style));
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_reg(logic [gb3_pkg::CFG_IDX_W-1:0] idx,
                             logic [gb3_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            gb3_pkg::REG_IMAGE_WIDTH:   reg_width  = data[gb3_pkg::WIDTH_W-1:0];
            gb3_pkg::REG_IMAGE_HEIGHT:  reg_height = data[gb3_pkg::HEIGHT_W-1:0];
            gb3_pkg::REG_CHANNEL_COUNT: reg_chans  = data[gb3_pkg::NCH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // all items taken, all results back, then let the pipeline settle
    task automatic wait_idle();
        while (items_accepted != items_queued || blurred_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // pixel driver: offers queued items, holds each until taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : pixel_driver
        pixel_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                blur_predict(on_bus);
                items_accepted++;
            end
            // port free: offer the next item unless this cycle idles
            if (!in_valid || in_ready)
            begin
                if (pixel_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 9))
                begin
                    nxt      = pixel_q.pop_front();
                    on_bus   = nxt;
                    in_valid <= 1'b1;
                    in_chan0 <= nxt[0];
                    in_chan1 <= nxt[1];
                    in_chan2 <= nxt[2];
                    in_chan3 <= nxt[3];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, in-order field comparison
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        gb3_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (blurred_q.size() == 0)
                begin
                    $error("unexpected result: chan %0d %0d %0d %0d, eos %b, eof %b",
                           out_chan0, out_chan1, out_chan2, out_chan3,
                           end_of_step, end_of_frame);
                    errors++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    check_field("out_chan0", want.chan[0], out_chan0);
                    check_field("out_chan1", want.chan[1], out_chan1);
                    check_field("out_chan2", want.chan[2], out_chan2);
                    check_field("out_chan3", want.chan[3], out_chan3);
                    check_field("end_of_step", 8'(want.eos), 8'(end_of_step));
                    check_field("end_of_frame", 8'(want.eof), 8'(end_of_frame));
                end
            end
            out_ready <= no_gaps || ($urandom_range(0, 99) >= 9);
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d items queued and %0d results owed",
                     items_queued - items_accepted, blurred_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int        new_w;
        int        new_h;
        int        span;
        int        part;
        int        random_pushed;
        px_style_e style;

        for (int i = 0; i < 2 * MAX_W; i++)
            line_mem[i] = '0;
        random_pushed = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single-column frame: width 0 saturates up to 1, channel count 7 down to 4,
        // plus a write to the unused index
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'h0000);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd3);
        write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'h0007);
        write_reg(REG_UNUSED, 16'($urandom));
        frames_run++;
        push_pixel({4{8'hFF}});
        push_pixel('0);
        push_pixel({4{8'hFF}});
        push_pixel(make_pixel(PX_NOISE));
        wait_idle();

        // three wide, one row, all four channels with alternating extremes
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd1);
        write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'd4);
        frames_run++;
        push_pixel(32'hFF00FF00);
        push_pixel(32'h00FF00FF);
        push_pixel(32'hFFFFFFFF);
        queue_pixels(3, PX_NOISE);
        wait_idle();

        // height 0 raised to 1; unused channels carry data but must read back 0
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd0);
        write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'd2);
        frames_run++;
        push_pixel(32'hFFFFAA55);
        push_pixel(32'h7FFF8001);
        queue_pixels(2, PX_NOISE);
        wait_idle();

        // tallest frame cut short: after two rows the height drops below the
        // row counter, so the next row becomes the drain row
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'd1);
        frames_run++;
        queue_pixels(6, PX_EXTREME);
        wait_idle();
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd1);
        queue_pixels(items_to_frame_end(), PX_NOISE);
        wait_idle();

        // random frames, mostly small, some broken off part way with narrower
        // rows or a changed height before they are finished
        while (random_pushed < RANDOM_ITEMS)
        begin
            frames_run++;
            case ($urandom_range(0, 9))
                0:       new_w = 0;
                1:       new_w = $urandom_range(13, 64);
                default: new_w = $urandom_range(1, 12);
            endcase
            new_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            write_reg(gb3_pkg::REG_IMAGE_WIDTH, {4'($urandom), 12'(new_w)});
            write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'(new_h));
            write_reg(gb3_pkg::REG_CHANNEL_COUNT,
                      {13'($urandom), 3'($urandom_range(0, 7))});
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, 16'($urandom));
            style = px_style_e'($urandom_range(0, 2));

            if ($urandom_range(0, 3) == 0)
            begin
                part = $urandom_range(0, items_to_frame_end() - 1);
                queue_pixels(part, style);
                random_pushed += part;
                wait_idle();
                // rows never widen mid-frame, the line store would be read unwritten
                if ($urandom_range(0, 1))
                    write_reg(gb3_pkg::REG_IMAGE_WIDTH,
                              16'($urandom_range(0, active_width())));
                if ($urandom_range(0, 1))
                    write_reg(gb3_pkg::REG_IMAGE_HEIGHT,
                              16'($urandom_range(0, active_height() + 2)));
                write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'($urandom_range(0, 7)));
            end
            span = items_to_frame_end();
            queue_pixels(span, style);
            random_pushed += span;
            wait_idle();
        end

        // no idling on either side: a row begun at 4095 wide (saturates to the
        // maximum) is cut short by a narrower width, so its next item closes
        // the row and a 40-wide drain row flushes the frame
        no_gaps = 1'b1;
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'h0000);
        write_reg(gb3_pkg::REG_CHANNEL_COUNT, 16'h0004);
        frames_run++;
        queue_pixels(200, PX_NOISE);
        wait_idle();
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd40);
        queue_pixels(items_to_frame_end(), PX_NOISE);
        wait_idle();
        no_gaps = 1'b0;

        // drained: anything owed now is a miss
        repeat (20) @(posedge clk);
        if (blurred_q.size() != 0)
        begin
            $error("%0d expected results never arrived", blurred_q.size());
            errors++;
        end

        $display("ran %0d frames: %0d pixels in, %0d blurred pixels out, %0d mismatches",
                 frames_run, items_accepted, results_seen, errors);
        $display("widths 1 to 64 and a saturated row, clamped registers, mid-frame cuts,");
        $display("random gaps on both sides and one long gap-free stretch");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
